// ===== rtl/core/facp_pkg.sv =====
// ----------------------------------------------------------------------------
// facp_pkg
// shared types and constants of the framed axis command parser
// ----------------------------------------------------------------------------
package facp_pkg;

    localparam logic [7:0] CHAR_OPEN  = 8'h3C;
    localparam logic [7:0] CHAR_CLOSE = 8'h3E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_O     = 8'h4F;
    localparam logic [7:0] CHAR_N     = 8'h4E;
    localparam logic [7:0] CHAR_F     = 8'h46;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    localparam logic [1:0] ACT_ENABLE  = 2'd0;
    localparam logic [1:0] ACT_DISABLE = 2'd1;
    localparam logic [1:0] ACT_MOVE    = 2'd2;

    localparam logic [2:0] WC_EMPTY = 3'd0;
    localparam logic [2:0] WC_O     = 3'd1;
    localparam logic [2:0] WC_ON    = 3'd2;
    localparam logic [2:0] WC_OF    = 3'd3;
    localparam logic [2:0] WC_OFF   = 3'd4;
    localparam logic [2:0] WC_NUM   = 3'd5;
    localparam logic [2:0] WC_OTHER = 3'd6;

    localparam int CMD_FIFO_DEPTH = 4;
    localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
    localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  axis;
        logic        negative;
        logic [15:0] magnitude;
    } cmd_t;

endpackage

// ===== rtl/core/facp_front.sv =====
// ----------------------------------------------------------------------------
// facp_front
// byte classifier: tracks frame, axis and body class, pushes commands on '>'
// ----------------------------------------------------------------------------
module facp_front
    import facp_pkg::*;
#(
    parameter int BODY_CHARS = 9
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    output logic       cmd_push,
    output cmd_t       cmd_data
);

    localparam int CW = $clog2(BODY_CHARS + 1);

    logic          in_frame_reg, in_frame_next;
    logic [7:0]    axis_reg, axis_next;
    logic [CW-1:0] count_reg, count_next;
    logic [2:0]    wc_reg, wc_next;
    logic          neg_reg, neg_next;
    logic          ended_reg, ended_next;
    logic [15:0]   num_reg, num_next;
    logic [7:0]    digit;

    assign digit = byte_data - CHAR_ZERO;

    always_comb begin
        in_frame_next = in_frame_reg;
        axis_next     = axis_reg;
        count_next    = count_reg;
        wc_next       = wc_reg;
        neg_next      = neg_reg;
        ended_next    = ended_reg;
        num_next      = num_reg;
        cmd_push      = 1'b0;
        cmd_data.action    = ACT_MOVE;
        cmd_data.axis      = axis_reg;
        cmd_data.negative  = neg_reg;
        cmd_data.magnitude = num_reg;
        if (byte_valid) begin
            if (!in_frame_reg && byte_data == CHAR_OPEN) begin
                in_frame_next = 1'b1;
                axis_next     = 8'd0;
                count_next    = '0;
                wc_next       = WC_EMPTY;
                neg_next      = 1'b0;
                ended_next    = 1'b0;
                num_next      = 16'd0;
            end else if (byte_data == CHAR_CLOSE) begin
                in_frame_next = 1'b0;
                if (wc_reg == WC_ON) begin
                    cmd_push        = 1'b1;
                    cmd_data.action = ACT_ENABLE;
                end else if (wc_reg == WC_OFF) begin
                    cmd_push        = 1'b1;
                    cmd_data.action = ACT_DISABLE;
                end else if (wc_reg == WC_NUM) begin
                    cmd_push        = 1'b1;
                    cmd_data.action = ACT_MOVE;
                end
            end else if (in_frame_reg) begin
                if (axis_reg == 8'd0) begin
                    axis_next = digit;
                end else if (count_reg < CW'(BODY_CHARS)) begin
                    count_next = count_reg + CW'(1);
                    if (!ended_reg) begin
                        if (byte_data == CHAR_NUL) begin
                            ended_next = 1'b1;
                        end else begin
                            unique case (wc_reg)
                                WC_EMPTY: begin
                                    if (byte_data == CHAR_PLUS) begin
                                        wc_next  = WC_NUM;
                                        neg_next = 1'b0;
                                    end else if (byte_data == CHAR_MINUS) begin
                                        wc_next  = WC_NUM;
                                        neg_next = 1'b1;
                                    end else if (byte_data == CHAR_O) begin
                                        wc_next = WC_O;
                                    end else begin
                                        wc_next = WC_OTHER;
                                    end
                                end
                                WC_O: begin
                                    if (byte_data == CHAR_N) begin
                                        wc_next = WC_ON;
                                    end else if (byte_data == CHAR_F) begin
                                        wc_next = WC_OF;
                                    end else begin
                                        wc_next = WC_OTHER;
                                    end
                                end
                                WC_OF: begin
                                    wc_next = (byte_data == CHAR_F) ? WC_OFF : WC_OTHER;
                                end
                                WC_NUM: begin
                                    if (byte_data >= CHAR_ZERO && byte_data <= CHAR_NINE) begin
                                        num_next = {num_reg[12:0], 3'b000}
                                                 + {num_reg[14:0], 1'b0}
                                                 + {8'd0, digit};
                                    end else begin
                                        ended_next = 1'b1;
                                    end
                                end
                                default: begin
                                    wc_next = WC_OTHER;
                                end
                            endcase
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            axis_reg     <= 8'd0;
            count_reg    <= '0;
            wc_reg       <= WC_EMPTY;
            neg_reg      <= 1'b0;
            ended_reg    <= 1'b0;
            num_reg      <= 16'd0;
        end else begin
            in_frame_reg <= in_frame_next;
            axis_reg     <= axis_next;
            count_reg    <= count_next;
            wc_reg       <= wc_next;
            neg_reg      <= neg_next;
            ended_reg    <= ended_next;
            num_reg      <= num_next;
        end
    end

endmodule

// ===== rtl/core/facp_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// facp_cmd_fifo
// short command queue between classifier and executor
// ----------------------------------------------------------------------------
module facp_cmd_fifo
    import facp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t pop_data
);

    cmd_t                 mem [CMD_FIFO_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg, count_next;
    logic                 do_push, do_pop;

    assign full      = (count_reg == CMD_CNT_W'(CMD_FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_FIFO_DEPTH - 1))
                        ? '0 : wr_ptr_reg + CMD_PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_FIFO_DEPTH - 1))
                        ? '0 : rd_ptr_reg + CMD_PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CMD_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CMD_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/facp_back.sv =====
// ----------------------------------------------------------------------------
// facp_back
// command executor: accumulates target position, drives result register
// ----------------------------------------------------------------------------
module facp_back
    import facp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cmd_valid,
    input  cmd_t        cmd_data,
    output logic        cmd_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_action,
    output logic [7:0]  m_axis,
    output logic signed [15:0] m_target_position
);

    logic        valid_reg;
    logic [1:0]  action_reg;
    logic [7:0]  axis_reg;
    logic [15:0] target_reg;
    logic [15:0] position_reg, position_next;
    logic [15:0] diff;

    assign cmd_pop = cmd_valid && (!valid_reg || m_ready);
    assign diff    = cmd_data.negative ? (16'd0 - cmd_data.magnitude) : cmd_data.magnitude;

    always_comb begin
        position_next = position_reg;
        if (cmd_pop && cmd_data.action == ACT_MOVE) begin
            position_next = position_reg + diff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            position_reg <= 16'd0;
        end else begin
            position_reg <= position_next;
            if (cmd_pop) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            action_reg <= cmd_data.action;
            axis_reg   <= cmd_data.axis;
            target_reg <= position_next;
        end
    end

    assign m_valid           = valid_reg;
    assign m_action          = action_reg;
    assign m_axis            = axis_reg;
    assign m_target_position = $signed(target_reg);

endmodule

// ===== rtl/core/framed_axis_command_parser_core.sv =====
// ----------------------------------------------------------------------------
// framed_axis_command_parser_core
// parses framed serial commands into enable, disable and move results
// ----------------------------------------------------------------------------
// One byte is taken every cycle. s_ready drops only while the four-entry
// command queue between the byte classifier and the executor is full, which
// happens only when the result side stalls. A closing '>' transaction puts its
// result into the queue; the executor's position adder and output register
// then pass it to the m_ channel, one result per cycle while m_ready is high.
module framed_axis_command_parser_core
    import facp_pkg::*;
#(
    parameter int BODY_CHARS = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_action,
    output logic [7:0]  m_axis,
    output logic signed [15:0] m_target_position
);

    logic cmd_push, fifo_full, fifo_valid, cmd_pop;
    cmd_t push_data, pop_data;

    assign s_ready = !fifo_full;

    facp_front #(
        .BODY_CHARS (BODY_CHARS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_valid && s_ready),
        .byte_data  (s_rx_byte),
        .cmd_push   (cmd_push),
        .cmd_data   (push_data)
    );

    facp_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (cmd_pop),
        .not_empty (fifo_valid),
        .pop_data  (pop_data)
    );

    facp_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd_valid         (fifo_valid),
        .cmd_data          (pop_data),
        .cmd_pop           (cmd_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_action          (m_action),
        .m_axis            (m_axis),
        .m_target_position (m_target_position)
    );

endmodule

// ===== rtl/core/facp_checker.sv =====
// ----------------------------------------------------------------------------
// facp_checker
// port-level checks of the framed axis command parser
// ----------------------------------------------------------------------------
module facp_checker
    import facp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_action,
    input logic [7:0]  m_axis,
    input logic [15:0] m_target_position
);

    logic [15:0] last_target_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_target_reg <= 16'd0;
        end else if (m_valid && m_ready) begin
            last_target_reg <= m_target_position;
        end
    end

    // stalled result transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_action) && $stable(m_axis)
            && $stable(m_target_position))
        else $error("stalled result changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_action == ACT_ENABLE || m_action == ACT_DISABLE
            || m_action == ACT_MOVE)
        else $error("undefined action code");

    // enable and disable leave the position where the last result left it
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action != ACT_MOVE |-> m_target_position == last_target_reg)
        else $error("position changed without a move");

    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid && s_ready)
        else $error("bad state after reset");

endmodule

bind framed_axis_command_parser_core facp_checker u_facp_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_action          (m_action),
    .m_axis            (m_axis),
    .m_target_position (m_target_position)
);

// ===== tb/sv/tb_framed_axis_command_parser_core.sv =====
// ----------------------------------------------------------------------------
// tb_framed_axis_command_parser_core
// self-checking bench for the framed axis command parser
// ----------------------------------------------------------------------------
// Bytes are sent as framed commands, noise and broken frames. An internal
// parser mirrors the block and queues each expected enable, disable or move
// command, and every result transaction is checked against the oldest entry.
// Both sides idle at random, the result side is held off long enough to
// fill the block, and the sender pauses at times until all results are in.
module tb_framed_axis_command_parser_core;
    import facp_pkg::*;

    localparam int BODY_CHARS = 9;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  axis;
        logic [15:0] target;
    } axis_cmd_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [7:0]        s_rx_byte = 8'd0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [1:0]        m_action;
    logic [7:0]        m_axis;
    logic signed [15:0] m_target_position;

    axis_cmd_t expected_cmds[$];
    axis_cmd_t want_cmd;
    int        mismatch_count = 0;
    int        bytes_sent = 0;
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    int        rx_hold_req = 0;
    int        rx_hold_left = 0;

    logic        frame_open = 1'b0;
    logic [7:0]  frame_axis = 8'd0;
    logic [3:0]  body_len = 4'd0;
    logic [2:0]  body_class = WC_EMPTY;
    logic        body_negative = 1'b0;
    logic        body_done = 1'b0;
    logic [15:0] body_magnitude = 16'd0;
    logic [15:0] target_pos = 16'd0;

    framed_axis_command_parser_core #(
        .BODY_CHARS(BODY_CHARS)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_action          (m_action),
        .m_axis            (m_axis),
        .m_target_position (m_target_position)
    );

    always #2 aclk = ~aclk;

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // result side ready, with long hold-off on request
    always @(posedge aclk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_cmds.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: action=%0d axis=%0d target=%0d",
                             m_action, m_axis, m_target_position);
            end else begin
                want_cmd = expected_cmds.pop_front();
                if (m_action !== want_cmd.action || m_axis !== want_cmd.axis ||
                    m_target_position !== want_cmd.target) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 want_cmd.action, want_cmd.axis, $signed(want_cmd.target),
                                 m_action, m_axis, m_target_position);
                end
            end
        end
    end

    task automatic clear_frame_body();
        body_len = 4'd0;
        body_class = WC_EMPTY;
        body_negative = 1'b0;
        body_done = 1'b0;
        body_magnitude = 16'd0;
    endtask

    task automatic add_body_byte(input logic [7:0] c);
        if (body_len < BODY_CHARS) begin
            body_len = body_len + 4'd1;
            if (!body_done) begin
                if (c == CHAR_NUL) begin
                    body_done = 1'b1;
                end else begin
                    case (body_class)
                        WC_EMPTY: begin
                            if (c == CHAR_PLUS) begin
                                body_class = WC_NUM;
                                body_negative = 1'b0;
                            end else if (c == CHAR_MINUS) begin
                                body_class = WC_NUM;
                                body_negative = 1'b1;
                            end else if (c == CHAR_O) begin
                                body_class = WC_O;
                            end else begin
                                body_class = WC_OTHER;
                            end
                        end
                        WC_O: begin
                            if (c == CHAR_N)
                                body_class = WC_ON;
                            else if (c == CHAR_F)
                                body_class = WC_OF;
                            else
                                body_class = WC_OTHER;
                        end
                        WC_OF: begin
                            body_class = (c == CHAR_F) ? WC_OFF : WC_OTHER;
                        end
                        WC_NUM: begin
                            if (c >= CHAR_ZERO && c <= CHAR_NINE)
                                body_magnitude = body_magnitude * 16'd10 +
                                                 {8'd0, c - CHAR_ZERO};
                            else
                                body_done = 1'b1;
                        end
                        default: begin
                            body_class = WC_OTHER;
                        end
                    endcase
                end
            end
        end
    endtask

    task automatic track_frame_byte(input logic [7:0] c);
        axis_cmd_t cmd;
        logic [15:0] delta;
        if (!frame_open && c == CHAR_OPEN) begin
            frame_open = 1'b1;
            frame_axis = 8'd0;
            clear_frame_body();
        end else if (c == CHAR_CLOSE) begin
            frame_open = 1'b0;
            if (body_class == WC_ON || body_class == WC_OFF || body_class == WC_NUM) begin
                if (body_class == WC_NUM) begin
                    delta = body_negative ? 16'd0 - body_magnitude : body_magnitude;
                    target_pos = target_pos + delta;
                    cmd.action = ACT_MOVE;
                end else begin
                    cmd.action = (body_class == WC_ON) ? ACT_ENABLE : ACT_DISABLE;
                end
                cmd.axis = frame_axis;
                cmd.target = target_pos;
                expected_cmds.push_back(cmd);
            end
        end else if (frame_open) begin
            if (frame_axis == 8'd0)
                frame_axis = c - CHAR_ZERO;
            else
                add_body_byte(c);
        end
    endtask

    // called at a rising edge; returns at the edge where the transaction happens
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        track_frame_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_cmds.size() != 0);
        repeat (6) @(posedge aclk);
    endtask

    task automatic send_random_frame();
        logic [7:0] body[$];
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        send_byte(CHAR_OPEN);
        if ($urandom_range(0, 9) == 0)
            send_byte(CHAR_ZERO);
        if ($urandom_range(0, 7) == 0)
            send_byte(8'($urandom_range(0, 255)));
        else
            send_byte(8'($urandom_range(8'h31, 8'h39)));
        if (kind < 28) begin
            body = '{CHAR_O, CHAR_N};
        end else if (kind < 46) begin
            body = '{CHAR_O, CHAR_F, CHAR_F};
        end else if (kind < 86) begin
            body.push_back($urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
            repeat (n) body.push_back(8'($urandom_range(8'h30, 8'h39)));
        end else begin
            n = $urandom_range(0, 10);
            repeat (n) body.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0)
            body.insert($urandom_range(0, body.size()), 8'($urandom_range(0, 255)));
        foreach (body[i])
            send_byte(body[i]);
        if ($urandom_range(0, 19) != 0)
            send_byte(CHAR_CLOSE);
        if ($urandom_range(0, 19) == 0)
            send_byte(CHAR_CLOSE);
    endtask

    task automatic test_frame_cases();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_text("<1ON>");
        send_text("<1OFF>");
        send_text("<2+360>");
        send_text("<2-360>");
        send_text(">");
        send_text("<><3>");
        send_text("<05ON>");
        send_text("<1+123456789012>");
        send_text("<1+99999>");
        send_text("<1-><1+12a3>");
        send_text("<1+4");
        send_byte(CHAR_NUL);
        send_text("7>");
        send_text("<<<ON>");
        send_byte(CHAR_OPEN);
        send_byte(8'hFF);
        send_text("OFF><1ONX><1OX>");
        wait_results_drained();
    endtask

    task automatic test_random_traffic(input int n_bytes, input int tx_pct, input int rx_pct);
        int start;
        start = bytes_sent;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (bytes_sent - start < n_bytes)
            send_random_frame();
        wait_results_drained();
    endtask

    task automatic test_result_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 300;
        repeat (30) send_text("<4+7>");
        send_text("<4-210>");
        wait_results_drained();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_frame_cases();
        test_random_traffic(130, 24, 57);
        test_result_backpressure();
        test_random_traffic(130, 57, 24);
        test_random_traffic(130, 0, 0);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && expected_cmds.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
